>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Asserts that a condition is never true at a rising clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/u16u8_pkg.sv
// Package with types, constants and encoding helpers of the UTF-16LE to UTF-8 encoder.
package u16u8_pkg;

    typedef logic [7:0] t_byte;

    // Number of UTF-8 bytes one unit can release at most.
    localparam int MAX_OUT_BYTES = 6;
    localparam int CNT_W         = $clog2(MAX_OUT_BYTES + 1);
    localparam int BUF_W         = MAX_OUT_BYTES * 8;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [BUF_W-1:0] t_obuf;

    // Top six bits of high and low surrogates.
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // UTF-8 lead and continuation prefixes.
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    function automatic logic [23:0] enc3(input logic [15:0] u);
        return {LEAD3_TAG, u[15:12], CONT_TAG, u[11:6], CONT_TAG, u[5:0]};
    endfunction

endpackage

>>> src/u16u8_in_if.sv
// Input channel: one UTF-16LE source byte per item.
interface u16u8_in_if;
    import u16u8_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  src_two_or_more;

    modport source (output valid, output in_byte, output src_two_or_more, input ready);
    modport sink   (input valid, input in_byte, input src_two_or_more, output ready);
endinterface

>>> src/u16u8_out_if.sv
// Output channel: one UTF-8 byte per item with its last-of-run mark.
interface u16u8_out_if;
    import u16u8_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> src/utf16le_to_utf8_encoder.sv
// Top level of the UTF-16LE to UTF-8 encoder.
//
//  Port   | Dir | Item                          | Handshake
//  i_in   | in  | in_byte, src_two_or_more      | valid/ready
//  o_out  | out | out_byte, last                | valid/ready
//
// The first byte of a unit is taken in any cycle and only stored.
// The second byte is encoded in the cycle it is taken; its 0 to 6 result bytes
// leave the shift buffer one per cycle while the output is ready, starting in the next cycle.
// It is taken when the buffer is empty or its final byte leaves in that cycle.
// Reset is synchronous and clears the held-byte flag, the held-surrogate flag and the buffer count.
module utf16le_to_utf8_encoder (
    input logic          i_clk,
    input logic          i_rst_n,
    u16u8_in_if.sink     i_in,
    u16u8_out_if.source  o_out
);
    import u16u8_pkg::*;

    logic        r_have_low;
    t_byte       r_low_byte;
    logic        r_pend_vld;
    logic [9:0]  r_pend;
    t_obuf       r_buf;
    t_cnt        r_cnt;

    logic        n_pend_vld;
    logic [9:0]  n_pend;
    t_obuf       n_buf;
    t_cnt        n_cnt;

    logic [15:0] w_unit;
    logic        w_is_hi;
    logic        w_is_lo;
    logic        w_in_acc;
    logic        w_unit_acc;
    logic        w_pop;
    logic [23:0] w_main;
    t_cnt        w_main_cnt;
    logic [23:0] w_flush;
    logic [4:0]  w_plane;

    assign w_unit   = {i_in.in_byte, r_low_byte};
    assign w_is_hi  = (w_unit[15:10] == HI_SURR_TAG);
    assign w_is_lo  = (w_unit[15:10] == LO_SURR_TAG);
    assign w_flush  = enc3({HI_SURR_TAG, r_pend});
    assign w_plane  = {1'b0, r_pend[9:6]} + 5'd1;

    assign i_in.ready = !r_have_low || (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && o_out.ready);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_unit_acc = w_in_acc && r_have_low;
    assign w_pop      = (r_cnt != '0) && o_out.ready;

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_buf[BUF_W-1 -: 8];
    assign o_out.last     = (r_cnt == t_cnt'(1));

    always_comb begin
        if (w_unit[15:7] == '0) begin
            w_main     = {w_unit[7:0], 16'h0000};
            w_main_cnt = t_cnt'(1);
        end else if (w_unit[15:11] == '0) begin
            w_main     = {LEAD2_TAG, w_unit[10:6], CONT_TAG, w_unit[5:0], 8'h00};
            w_main_cnt = t_cnt'(2);
        end else begin
            w_main     = enc3(w_unit);
            w_main_cnt = t_cnt'(3);
        end
    end

    always_comb begin
        n_pend_vld = 1'b0;
        n_pend     = w_unit[9:0];
        if (w_is_hi && i_in.src_two_or_more) begin
            n_pend_vld = 1'b1;
            n_buf      = {w_flush, 24'h000000};
            n_cnt      = r_pend_vld ? t_cnt'(3) : '0;
        end else if (r_pend_vld && w_is_lo) begin
            n_buf = {LEAD4_TAG, w_plane[4:2],
                     CONT_TAG, w_plane[1:0], r_pend[5:2],
                     CONT_TAG, r_pend[1:0], w_unit[9:6],
                     CONT_TAG, w_unit[5:0], 16'h0000};
            n_cnt = t_cnt'(4);
        end else if (r_pend_vld) begin
            n_buf = {w_flush, w_main};
            n_cnt = t_cnt'(3) + w_main_cnt;
        end else begin
            n_buf = {w_main, 24'h000000};
            n_cnt = w_main_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_low <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (w_in_acc) begin
                r_have_low <= !r_have_low;
            end
            if (w_unit_acc) begin
                r_pend_vld <= n_pend_vld;
                r_cnt      <= n_cnt;
            end else if (w_pop) begin
                r_cnt <= r_cnt - t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !r_have_low) begin
            r_low_byte <= i_in.in_byte;
        end
        if (w_unit_acc) begin
            r_pend <= n_pend;
            r_buf  <= n_buf;
        end else if (w_pop) begin
            r_buf <= {r_buf[BUF_W-9:0], 8'h00};
        end
    end

endmodule

>>> src/u16u8_chk.sv
// Port checker of the UTF-16LE to UTF-8 encoder and its bind statement.
`include "assert_macros.svh"

module u16u8_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    logic r_odd;
    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // Set while the next input item is the second byte of a unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd <= 1'b0;
        end else if (w_in_acc) begin
            r_odd <= !r_odd;
        end
    end

    `AST_HOLDS(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
    `AST_HOLDS(a_first_byte_ready, i_clk, i_rst_n, !r_odd |-> i_in_ready)
    `AST_NEVER(a_second_byte_overrun, i_clk, i_rst_n, w_in_acc && r_odd && i_out_valid && !(i_out_ready && i_out_last))
    `AST_HOLDS(a_first_byte_silent, i_clk, i_rst_n, w_in_acc && !r_odd && !i_out_valid |=> !i_out_valid)

endmodule

bind utf16le_to_utf8_encoder u16u8_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-16LE to UTF-8 encoder: directed and random traffic with a scoreboard.
module testbench;
    import u16u8_pkg::*;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST = 16'hDBFF;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST = 16'hDFFF;
    localparam logic [20:0] PLANE1_BASE  = 21'h10000;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_byte data;
        logic  last;
    } utf8_item_t;

    class utf8_tracker;
        logic        have_low     = 1'b0;
        t_byte       low_byte     = '0;
        logic [15:0] pending_high = '0;
        utf8_item_t  expected_utf8[$];
        int          errors = 0;
        int          checked = 0;
        int          quads = 0;

        function void push_byte(input t_byte b);
            expected_utf8.push_back('{data: b, last: 1'b0});
        endfunction

        function void push_three(input logic [15:0] u);
            push_byte({4'b1110, u[15:12]});
            push_byte({2'b10, u[11:6]});
            push_byte({2'b10, u[5:0]});
        endfunction

        function void take_utf16_byte(input t_byte b, input logic two_left);
            logic [15:0] unit;
            logic [20:0] cp;
            int          first;
            first = expected_utf8.size();
            if (!have_low) begin
                low_byte = b;
                have_low = 1'b1;
                return;
            end
            have_low = 1'b0;
            unit = {b, low_byte};
            if (unit >= HI_SURR_BASE && unit <= HI_SURR_LAST && two_left) begin
                if (pending_high != 0)
                    push_three(pending_high);
                pending_high = unit;
            end else if (pending_high != 0 && unit >= LO_SURR_BASE && unit <= LO_SURR_LAST) begin
                cp = ((pending_high - HI_SURR_BASE) << 10) + (unit - LO_SURR_BASE) + PLANE1_BASE;
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
                pending_high = '0;
                quads++;
            end else begin
                if (pending_high != 0) begin
                    push_three(pending_high);
                    pending_high = '0;
                end
                if (unit[15:7] == 0) begin
                    push_byte(unit[7:0]);
                end else if (unit[15:11] == 0) begin
                    push_byte({3'b110, unit[10:6]});
                    push_byte({2'b10, unit[5:0]});
                end else begin
                    push_three(unit);
                end
            end
            if (expected_utf8.size() > first)
                expected_utf8[expected_utf8.size() - 1].last = 1'b1;
        endfunction

        function void check_utf8_byte(input t_byte b, input logic last);
            utf8_item_t want;
            checked++;
            if (expected_utf8.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected output item: byte %h last %b.", b, last);
                return;
            end
            want = expected_utf8.pop_front();
            if (want.data !== b || want.last !== last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Output item %0d: expected byte %h last %b, got byte %h last %b.",
                             checked, want.data, want.last, b, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    utf8_tracker tracker;
    int          idle_pct;
    int          stall_pct;
    int          hold_requests;
    int          holds_served;
    int          units_sent;
    int          bytes_in;
    int          quiet_cycles;

    u16u8_in_if  in_ch ();
    u16u8_out_if out_ch ();

    utf16le_to_utf8_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic send_byte(input t_byte b, input logic two_left);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.in_byte         <= b;
        in_ch.src_two_or_more <= two_left;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_utf16_byte(b, two_left);
        bytes_in++;
    endtask

    task automatic send_unit(input logic [15:0] unit, input logic two_on_high);
        send_byte(unit[7:0], 1'($urandom_range(1)));
        send_byte(unit[15:8], two_on_high);
        units_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.expected_utf8.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_unit();
        int   pick;
        logic coin;
        pick = $urandom_range(99);
        coin = 1'($urandom_range(1));
        if (pick < 18) begin
            send_unit(16'($urandom_range(16'h007F)), coin);
        end else if (pick < 32) begin
            send_unit(16'($urandom_range(16'h07FF, 16'h0080)), coin);
        end else if (pick < 50) begin
            send_unit(16'($urandom_range(16'hFFFF, 16'h0800)), coin);
        end else if (pick < 78) begin
            send_unit(HI_SURR_BASE + 16'($urandom_range(16'h03FF)), 1'b1);
            send_unit(LO_SURR_BASE + 16'($urandom_range(16'h03FF)), coin);
        end else if (pick < 88) begin
            send_unit(16'($urandom_range(16'hFFFF)), coin);
        end else if (pick < 94) begin
            send_unit(HI_SURR_BASE + 16'($urandom_range(16'h03FF)), coin);
        end else begin
            send_unit(LO_SURR_BASE + 16'($urandom_range(16'h03FF)), coin);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_bytes);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = bytes_in + n_bytes;
        while (bytes_in < target)
            random_unit();
        wait_drained();
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_utf8_byte(out_ch.out_byte, out_ch.last);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("utf16le_to_utf8_encoder verification failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid           = 1'b0;
        in_ch.in_byte         = '0;
        in_ch.src_two_or_more = 1'b0;
        i_rst_n       = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        holds_served  = 0;
        units_sent    = 0;
        bytes_in      = 0;
        quiet_cycles  = 0;
        tracker = new;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_unit(16'h007F, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b1);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD800, 1'b1);
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hD834, 1'b0);
        send_unit(16'hDC00, 1'b1);
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'h0041, 1'b1);
        send_unit(16'hD8AA, 1'b1);
        send_unit(16'hDA00, 1'b0);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (30) random_unit();
        wait_drained();

        run_phase(0, 0, 90);
        run_phase(59, 0, 110);
        run_phase(0, 59, 110);
        run_phase(32, 32, 110);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d UTF-16 units in %0d input items and %0d UTF-8 output items.",
                 units_sent, bytes_in, tracker.checked);
        $display("Built %0d four-byte sequences under free flow, input gaps, output stalls, both, and a %0d-cycle output hold-off.",
                 tracker.quads, HOLD_CYCLES);
        if (tracker.errors == 0) begin
            $display("utf16le_to_utf8_encoder verification clean");
        end else begin
            $display("%0d mismatches in total.", tracker.errors);
            $display("utf16le_to_utf8_encoder verification failed");
        end
        $finish;
    end
endmodule
